@@ rtl/lrucc_pkg.sv @@
// Package for the LRU checkout cache: request, result, entry, neighbor link and scan token types.
// Holds the fixed field widths and operation codes. Depends on nothing.
package lrucc_pkg;

   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 16;
   localparam int CFG_BITS   = 7;

   localparam logic [CFG_BITS-1:0] CFG_RESET = 7'd64;

   localparam logic KIND_PUT   = 1'b0;
   localparam logic KIND_FETCH = 1'b1;

   typedef struct packed {
      logic                  kind;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value_in;
   } req_type;

   typedef struct packed {
      logic                  hit;
      logic [VALUE_BITS-1:0] value_out;
      logic                  dropped;
      logic [VALUE_BITS-1:0] dropped_value;
   } rsp_type;

   typedef struct packed {
      logic                  valid;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } entry_type;

   // What a cell offers its upstream neighbor: its entry, and a load strobe
   // that closes the gap left by a fetch.
   typedef struct packed {
      logic      load;
      entry_type ent;
   } back_type;

   // The scan token that walks the chain, one cell per cycle.
   typedef struct packed {
      logic                  active;
      logic                  kind;
      logic                  done;
      logic                  evict;
      logic [KEY_BITS-1:0]   key;
      logic [KEY_BITS-1:0]   carry_key;
      logic [VALUE_BITS-1:0] carry_value;
      logic                  hit;
      logic [VALUE_BITS-1:0] value_out;
      logic                  dropped;
      logic [VALUE_BITS-1:0] dropped_value;
   } tok_type;

endpackage

@@ rtl/lru_checkout_cache.sv @@
// Top level of the LRU checkout cache: capacity register, request control,
// the chain of cells and the result queue. Depends on lrucc_pkg, lrucc_cell, lrucc_outq.
//
//   port group   direction  payload    handshake
//   req_*        in         req_type   req_valid / req_ready
//   rsp_*        out        rsp_type   rsp_valid / rsp_ready
//   csr_*        in         7 bits     csr_valid / csr_ready (always ready)
//
// A request that reaches the chain has its result offered after the scan token has
// walked the chain one cell per cycle and the result has entered the result queue.
// With the capacity register at zero the result is offered in the cycle right after
// acceptance. One request is in the chain at a time, so a request that uses the chain
// is not accepted while an earlier one is still in the chain; a new one is accepted
// in the cycle after the token has left, while up to one earlier result still waits
// in the result queue.
// Reset clears all valid bits and the token stages at once; there is no clearing pass.
// A stalled result channel holds the queue and, once both slots are full, req_ready.
module lru_checkout_cache
   import lrucc_pkg::*;
#(
   parameter int CAPACITY = 64
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CFG_BITS-1:0] csr_data
);

   localparam int CNT_BITS = $clog2(CAPACITY + 1);
   localparam int CMP_BITS = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;
   localparam logic [CMP_BITS-1:0] CAP_LIMIT = CMP_BITS'(CAPACITY);

   // Capacity register. The user must write it only while the cache is idle; the block does not enforce this.
   logic [CFG_BITS-1:0] max_entries_ff, max_entries_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                busy_ff, busy_in;

   logic [CMP_BITS-1:0] max_ext, count_ext, cap_ext;
   logic                cap_zero;
   logic                accept;
   logic                launch;
   logic                chain_done;
   logic                push;
   rsp_type             push_data;
   logic                q_full;

   tok_type             tok_head;
   tok_type             tok_link  [0:CAPACITY];
   back_type            back_link [0:CAPACITY];
   logic [CAPACITY-1:0] valid_vec;
   logic [CAPACITY-1:0] tok_act;

   assign csr_ready      = 1'b1;
   assign max_entries_in = (csr_valid && csr_ready) ? csr_data : max_entries_ff;

   // A capacity register above the cell count acts as the cell count.
   assign max_ext   = CMP_BITS'(max_entries_ff);
   assign count_ext = CMP_BITS'(count_ff);
   assign cap_ext   = (max_ext > CAP_LIMIT) ? CAP_LIMIT : max_ext;
   assign cap_zero  = (max_entries_ff == '0);

   assign req_ready = !busy_ff && !q_full;
   assign accept    = req_valid && req_ready;
   assign launch    = accept && !cap_zero;

   // The token enters cell 0 carrying the new entry; a put of an absent key evicts
   // the least recent entry when the cache is at or over its capacity.
   always_comb begin
      tok_head             = '0;
      tok_head.active      = launch;
      tok_head.kind        = req_data.kind;
      tok_head.evict       = (count_ext >= cap_ext);
      tok_head.key         = req_data.key;
      tok_head.carry_key   = req_data.key;
      tok_head.carry_value = req_data.value_in;
   end

   assign tok_link[0]         = tok_head;
   assign back_link[CAPACITY] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      lrucc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .tok_in   (tok_link[i]),
         .tok_out  (tok_link[i+1]),
         .back_in  (back_link[i+1]),
         .back_out (back_link[i])
      );
      assign valid_vec[i] = back_link[i].ent.valid;
      assign tok_act[i]   = tok_link[i+1].active;
   end

   assign chain_done = tok_link[CAPACITY].active;

   // The entry count moves only when a token leaves the chain: a fetch hit frees
   // one entry, and a put that discards nothing adds one.
   always_comb begin
      count_in = count_ff;
      busy_in  = busy_ff;
      if (launch) begin
         busy_in = 1'b1;
      end
      if (chain_done) begin
         busy_in = 1'b0;
         if (tok_link[CAPACITY].kind == KIND_FETCH) begin
            if (tok_link[CAPACITY].hit) begin
               count_in = count_ff - CNT_BITS'(1);
            end
         end else if (!tok_link[CAPACITY].dropped) begin
            count_in = count_ff + CNT_BITS'(1);
         end
      end
   end

   // With the cache off, a put drops its own handle and a fetch misses.
   always_comb begin
      push      = chain_done || (accept && cap_zero);
      push_data = '0;
      if (chain_done) begin
         push_data.hit           = tok_link[CAPACITY].hit;
         push_data.value_out     = tok_link[CAPACITY].value_out;
         push_data.dropped       = tok_link[CAPACITY].dropped;
         push_data.dropped_value = tok_link[CAPACITY].dropped_value;
      end else if (req_data.kind == KIND_PUT) begin
         push_data.dropped       = 1'b1;
         push_data.dropped_value = req_data.value_in;
      end
   end

   lrucc_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff <= CFG_RESET;
         count_ff       <= '0;
         busy_ff        <= 1'b0;
      end else begin
         max_entries_ff <= max_entries_in;
         count_ff       <= count_in;
         busy_ff        <= busy_in;
      end
   end

   // Only one token walks the chain at a time.
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $countones(tok_act) <= 1)
      else $error("more than one scan token in the chain");

   // A token leaves the chain only while a request is in progress.
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      chain_done |-> busy_ff)
      else $error("scan token left the chain while idle");

   // Between requests the valid entries fill the chain from the head without gaps.
   a_packed: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (((valid_vec + CAPACITY'(1)) & valid_vec) == '0))
      else $error("valid entries are not packed toward the head");

   // Between requests the entry count equals the number of valid cells.
   a_count: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> ($countones(valid_vec) == int'(count_ff)))
      else $error("entry count disagrees with the valid cells");

   // The count changes only at the end of a scan.
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !chain_done |=> $stable(count_ff))
      else $error("entry count changed outside a scan end");

endmodule

@@ rtl/lrucc_cell.sv @@
// One cache cell: a stored entry plus the token stage that visits it.
// Depends on lrucc_pkg.
module lrucc_cell
   import lrucc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  tok_type  tok_in,
   output tok_type  tok_out,
   input  back_type back_in,
   output back_type back_out
);

   logic                  valid_ff, valid_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   tok_type               tok_ff;
   tok_type               tok_nx;
   logic                  load;
   logic                  match;

   assign match = valid_ff && (key_ff == tok_ff.key);

   always_comb begin
      tok_nx   = tok_ff;
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      load     = 1'b0;
      if (back_in.load) begin
         valid_in = back_in.ent.valid;
         key_in   = back_in.ent.key;
         value_in = back_in.ent.value;
      end
      if (tok_ff.active) begin
         if (tok_ff.kind == KIND_FETCH) begin
            if (tok_ff.done) begin
               // Entries past the removed one move one place toward the head.
               load     = 1'b1;
               valid_in = 1'b0;
            end else if (match) begin
               tok_nx.done      = 1'b1;
               tok_nx.hit       = 1'b1;
               tok_nx.value_out = value_ff;
               valid_in         = 1'b0;
            end
         end else if (!tok_ff.done) begin
            if (match) begin
               tok_nx.done          = 1'b1;
               tok_nx.dropped       = 1'b1;
               tok_nx.dropped_value = value_ff;
               key_in               = tok_ff.carry_key;
               value_in             = tok_ff.carry_value;
            end else if (!valid_ff) begin
               tok_nx.done = 1'b1;
               valid_in    = 1'b1;
               key_in      = tok_ff.carry_key;
               value_in    = tok_ff.carry_value;
            end else begin
               key_in   = tok_ff.carry_key;
               value_in = tok_ff.carry_value;
               if (tok_ff.evict && !back_in.ent.valid) begin
                  // Last valid entry is the least recent one: it leaves.
                  tok_nx.done          = 1'b1;
                  tok_nx.dropped       = 1'b1;
                  tok_nx.dropped_value = value_ff;
               end else begin
                  tok_nx.carry_key   = key_ff;
                  tok_nx.carry_value = value_ff;
               end
            end
         end
      end
   end

   assign tok_out        = tok_nx;
   assign back_out.load  = load;
   assign back_out.ent   = '{valid: valid_ff, key: key_ff, value: value_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         tok_ff.active <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
      key_ff   <= key_in;
      value_ff <= value_in;
   end

endmodule

@@ rtl/lrucc_outq.sv @@
// Two-entry result queue between the cache core and the result channel.
// Depends on lrucc_pkg.
module lrucc_outq
   import lrucc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    head_v_ff, head_v_in, tail_v_ff, tail_v_in;
   rsp_type head_ff, head_in, tail_ff, tail_in;

   always_comb begin
      head_v_in = head_v_ff;
      head_in   = head_ff;
      tail_v_in = tail_v_ff;
      tail_in   = tail_ff;
      if (head_v_ff && rsp_ready) begin
         head_v_in = tail_v_ff;
         head_in   = tail_ff;
         tail_v_in = 1'b0;
      end
      if (push) begin
         if (!head_v_in) begin
            head_v_in = 1'b1;
            head_in   = push_data;
         end else begin
            tail_v_in = 1'b1;
            tail_in   = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_v_ff <= 1'b0;
         tail_v_ff <= 1'b0;
      end else begin
         head_v_ff <= head_v_in;
         tail_v_ff <= tail_v_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign full      = tail_v_ff;
   assign rsp_valid = head_v_ff;
   assign rsp_data  = head_ff;

endmodule

@@ bench/tb_lru_checkout_cache.sv @@
// Self-checking testbench for lru_checkout_cache: directed and random put and fetch
// requests checked against a behavioral model of the LRU cache kept in this file.
// Depends on lrucc_pkg and the lru_checkout_cache RTL.
module tb_lru_checkout_cache;
   import lrucc_pkg::*;

   localparam int CACHE_SLOTS   = 64;
   // Watchdog limit for the whole run, chosen with a wide margin.
   localparam int CYCLE_LIMIT   = 500000;
   // Settling wait that lets the scan token leave the chain before the cache counts as idle.
   localparam int SETTLE_CYCLES = CACHE_SLOTS + 8;
   localparam int POOL_DEPTH    = 96;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CFG_BITS-1:0] csr_data  = '0;

   // Behavioral copy of the cache contents. Age 0 is the most recent entry.
   logic [KEY_BITS-1:0]   slot_key   [CACHE_SLOTS];
   logic [VALUE_BITS-1:0] slot_value [CACHE_SLOTS];
   bit                    slot_used  [CACHE_SLOTS];
   int unsigned           slot_age   [CACHE_SLOTS];
   int unsigned           used_count   = 0;
   logic [CFG_BITS-1:0]   capacity_reg = CFG_RESET;

   // Results still owed by the cache, oldest first.
   rsp_type pending_outcomes[$];

   int fail_count    = 0;
   int cycle_count   = 0;
   int send_idle_pct = 21;
   int recv_idle_pct = 77;
   // A test asks for a long receiver stall by setting hold_request; the receiver
   // process picks it up and counts it down in hold_left.
   int hold_request  = 0;
   int hold_left     = 0;

   always #2 clock = ~clock;

   lru_checkout_cache #(
      .CAPACITY(CACHE_SLOTS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   // Returns the slot that holds key k, or -1 when the key is not cached.
   function automatic int find_slot(input logic [KEY_BITS-1:0] k);
      for (int i = 0; i < CACHE_SLOTS; i++)
         if (slot_used[i] && slot_key[i] == k)
            return i;
      return -1;
   endfunction

   // Frees a slot; every entry older than it moves one step toward most recent.
   function automatic void release_slot(input int s);
      int unsigned gone_age;
      gone_age     = slot_age[s];
      slot_used[s] = 1'b0;
      for (int i = 0; i < CACHE_SLOTS; i++)
         if (slot_used[i] && slot_age[i] > gone_age)
            slot_age[i]--;
      if (used_count > 0)
         used_count--;
   endfunction

   // Applies one request to the behavioral cache and returns the result it must give.
   function automatic rsp_type cache_outcome(input req_type r);
      rsp_type     res;
      int unsigned eff;
      int unsigned old_age;
      int          s;
      int          f;
      res = '0;
      eff = (capacity_reg > CACHE_SLOTS) ? CACHE_SLOTS : capacity_reg;
      s   = -1;
      f   = -1;
      if (r.kind == KIND_FETCH) begin
         // A fetch checks the handle out: the entry leaves the cache on a hit.
         if (eff != 0) begin
            s = find_slot(r.key);
            if (s >= 0) begin
               res.hit       = 1'b1;
               res.value_out = slot_value[s];
               release_slot(s);
            end
         end
      end else if (eff == 0) begin
         // Disabled cache: the handle is dropped, stored entries stay untouched.
         res.dropped       = 1'b1;
         res.dropped_value = r.value_in;
      end else begin
         s = find_slot(r.key);
         if (s >= 0) begin
            // Replacement: old handle dropped, entry becomes most recent.
            res.dropped       = 1'b1;
            res.dropped_value = slot_value[s];
            slot_value[s]     = r.value_in;
            old_age           = slot_age[s];
            for (int i = 0; i < CACHE_SLOTS; i++)
               if (slot_used[i] && i != s && slot_age[i] < old_age)
                  slot_age[i]++;
            slot_age[s] = 0;
         end else begin
            // A full (or shrunk) cache evicts exactly one least recent entry.
            if (used_count > 0 && used_count >= eff) begin
               for (int i = 0; i < CACHE_SLOTS; i++)
                  if (slot_used[i] && (s < 0 || slot_age[i] > slot_age[s]))
                     s = i;
               if (s >= 0) begin
                  res.dropped       = 1'b1;
                  res.dropped_value = slot_value[s];
                  release_slot(s);
               end
            end
            for (int i = 0; i < CACHE_SLOTS; i++)
               if (!slot_used[i] && f < 0)
                  f = i;
            if (f >= 0) begin
               for (int i = 0; i < CACHE_SLOTS; i++)
                  if (slot_used[i])
                     slot_age[i]++;
               slot_used[f]  = 1'b1;
               slot_key[f]   = r.key;
               slot_value[f] = r.value_in;
               slot_age[f]   = 0;
               used_count++;
            end
         end
      end
      return res;
   endfunction

   // Offers one request after a random number of idle cycles, waits until the cache
   // takes it, then records the result it must produce. Called just after a rising
   // edge; returns just after the edge at which the request was accepted.
   task automatic send_request(input req_type r);
      while (int'($urandom_range(99, 0)) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do
         @(posedge clock);
      while (!req_ready);
      pending_outcomes.push_back(cache_outcome(r));
   endtask

   task automatic put_handle(input logic [KEY_BITS-1:0] k, input logic [VALUE_BITS-1:0] v);
      req_type r;
      r.kind     = KIND_PUT;
      r.key      = k;
      r.value_in = v;
      send_request(r);
   endtask

   // The value field of a fetch is ignored by the cache; it is randomized anyway.
   task automatic fetch_handle(input logic [KEY_BITS-1:0] k);
      req_type r;
      r.kind     = KIND_FETCH;
      r.key      = k;
      r.value_in = VALUE_BITS'($urandom());
      send_request(r);
   endtask

   // Stops offering requests until every owed result has come, then lets the chain
   // settle so the cache is idle.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Capacity is only changed while the cache is idle.
   task automatic write_capacity(input logic [CFG_BITS-1:0] v);
      wait_for_results();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid    <= 1'b0;
      capacity_reg  = v;
   endtask

   // Extreme keys and handles, replacement, hit, double fetch and a plain miss
   // at the reset capacity.
   task automatic test_put_fetch_basics();
      put_handle(32'h0000_0000, 16'h0000);
      put_handle(32'hFFFF_FFFF, 16'hFFFF);
      fetch_handle(32'h0000_0000);
      fetch_handle(32'h0000_0000);
      put_handle(32'hFFFF_FFFF, 16'h1234);
      fetch_handle(32'hFFFF_FFFF);
      fetch_handle(32'h5555_AAAA);
   endtask

   // Least recent eviction at capacity one and two, and a replacement that
   // refreshes an entry so that another one becomes the eviction victim.
   task automatic test_lru_eviction();
      write_capacity(7'd1);
      put_handle(32'hA5A5_0001, 16'h0001);
      put_handle(32'h5A5A_0002, 16'h0002);
      fetch_handle(32'hA5A5_0001);
      write_capacity(7'd2);
      put_handle(32'h0F0F_0003, 16'h0003);
      put_handle(32'h5A5A_0002, 16'h0004);
      put_handle(32'hF0F0_0004, 16'h0005);
      fetch_handle(32'h5A5A_0002);
   endtask

   // A disabled cache drops puts and misses fetches but keeps its entries; an
   // oversized capacity acts as the full size; a shrunk capacity evicts one
   // entry per new key.
   task automatic test_disabled_and_shrunk();
      write_capacity(7'd3);
      put_handle(32'h1234_5678, 16'h0006);
      put_handle(32'h8765_4321, 16'h0007);
      write_capacity(7'd0);
      put_handle(32'hDEAD_BEEF, 16'h8008);
      fetch_handle(32'h1234_5678);
      write_capacity(7'd127);
      fetch_handle(32'h1234_5678);
      write_capacity(7'd1);
      put_handle(32'hCAFE_0001, 16'h0009);
      put_handle(32'hCAFE_0002, 16'h000A);
      write_capacity(CFG_RESET);
   endtask

   // The receiver stalls for a long stretch while requests keep coming, so the
   // result queue fills and the cache must hold req_ready low. The sender then
   // pauses until every result is out.
   task automatic test_full_backpressure();
      hold_request = 600;
      for (int n = 0; n < 10; n++) begin
         if (n % 3 == 2)
            fetch_handle(32'hB000_0000 + (n - 2));
         else
            put_handle(32'hB000_0000 + n, VALUE_BITS'($urandom()));
      end
      wait_for_results();
   endtask

   // Random puts and fetches at one capacity. Keys mostly come from a pool a bit
   // larger than the capacity, so hits, replacements and evictions all occur;
   // now and then a fresh key forces a miss.
   task automatic test_random_traffic(input int n_items, input logic [CFG_BITS-1:0] cap);
      logic [KEY_BITS-1:0] pool [POOL_DEPTH];
      int                  pool_size;
      int                  eff;
      req_type             r;
      write_capacity(cap);
      eff       = (cap > CACHE_SLOTS) ? CACHE_SLOTS : cap;
      pool_size = eff + eff / 2 + 4;
      if (pool_size > POOL_DEPTH)
         pool_size = POOL_DEPTH;
      foreach (pool[i])
         pool[i] = $urandom();
      pool[0] = '0;
      pool[1] = '1;
      for (int n = 0; n < n_items; n++) begin
         r.kind     = (int'($urandom_range(99, 0)) < 45) ? KIND_FETCH : KIND_PUT;
         r.key      = ($urandom_range(15, 0) == 0) ? $urandom()
                                                   : pool[$urandom_range(pool_size - 1, 0)];
         r.value_in = VALUE_BITS'($urandom());
         send_request(r);
      end
   endtask

   // Receiver: random stalls at the current rate, or a long hold when a test asks.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (int'($urandom_range(99, 0)) >= recv_idle_pct);
      end
   end

   // Each accepted result is checked against the oldest owed result.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            $error("result with no request outstanding: %p", rsp_data);
            fail_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_data.hit !== want.hit) begin
               $error("hit: expected %0h, actual %0h", want.hit, rsp_data.hit);
               fail_count++;
            end
            if (rsp_data.value_out !== want.value_out) begin
               $error("value_out: expected %0h, actual %0h", want.value_out,
                      rsp_data.value_out);
               fail_count++;
            end
            if (rsp_data.dropped !== want.dropped) begin
               $error("dropped: expected %0h, actual %0h", want.dropped, rsp_data.dropped);
               fail_count++;
            end
            if (rsp_data.dropped_value !== want.dropped_value) begin
               $error("dropped_value: expected %0h, actual %0h", want.dropped_value,
                      rsp_data.dropped_value);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_put_fetch_basics();
      test_lru_eviction();
      test_disabled_and_shrunk();
      test_full_backpressure();

      // Sender mostly busy, receiver mostly stalling.
      test_random_traffic(95, 7'd64);
      test_random_traffic(95, 7'd5);
      test_random_traffic(95, 7'd127);

      // Roles swapped: sparse requests, eager receiver.
      send_idle_pct = 77;
      recv_idle_pct = 21;
      test_random_traffic(95, 7'd1);
      test_random_traffic(95, 7'd0);
      test_random_traffic(95, 7'd40);

      // Neither side idles.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(95, 7'd2);
      test_random_traffic(95, 7'd64);
      test_random_traffic(90, 7'd17);

      wait_for_results();
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
